// ===== hw/rtl/hamming_neighbor_enumerator_defines.svh =====
// Assertion macros used by the enumerator top level.
`ifndef HAMMING_NEIGHBOR_ENUMERATOR_DEFINES_SVH
`define HAMMING_NEIGHBOR_ENUMERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define HNE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hne assertion failed");

`define HNE_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hne forbidden condition seen");

`else

`define HNE_ASSERT(name, clk, rst_n, prop)

`define HNE_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/hne_pkg.sv =====
// Types and constants shared by the Hamming neighbor enumerator.
package hne_pkg;

  localparam int unsigned DataBits = 16;
  localparam int unsigned DistBits = 5;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [DataBits-1:0] base_word;
  } in_word_t;

  typedef struct packed {
    logic more_left;
    logic neighbor_valid;
  } out_flags_t;

endpackage

// ===== hw/rtl/hamming_neighbor_enumerator.sv =====
// Top level: Hamming neighbor enumerator with stream ports and a distance register.
// A start word (tuser = 0) loads the base in tdata and arms the first mask of
// weight flip_distance; each next word (tuser = 1) returns base XOR the current
// mask, masks running in descending numeric order, then steps the mask. Every
// input word yields exactly one output word. Throughput is one word per cycle
// while the output is not stalled; a word passes the input register and then
// the result register, with the mask step done between them. The new distance
// written on the config port takes effect at the next start.
`include "hamming_neighbor_enumerator_defines.svh"

module hamming_neighbor_enumerator #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // flip_distance
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] base_word
  input  logic [0:0]  s_axis_tuser_i,  // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] neighbor_word
  output logic [1:0]  m_axis_tuser_o   // [0] neighbor_valid, [1] more_left
);

  localparam int unsigned DataW    = hne_pkg::DataBits;
  localparam int unsigned DistW    = hne_pkg::DistBits;
  localparam int unsigned BaseBits = (WORD_BITS < DataW) ? WORD_BITS : DataW;

  hne_pkg::in_word_t  in_word;
  hne_pkg::in_word_t  s1_word;
  logic               s1_valid;
  logic               s1_ready;
  logic               adv;

  logic [DistW-1:0]     dist_q;
  logic [BaseBits-1:0]  held_base_q, held_base_d;
  logic [WORD_BITS-1:0] mask_q, mask_d;
  logic                 pend_q, pend_d;
  logic [WORD_BITS-1:0] start_mask;
  logic [WORD_BITS-1:0] next_mask;
  logic                 has_next;
  logic                 dist_over;

  logic                 out_valid_q;
  logic [DataW-1:0]     out_word_q, out_word_d;
  hne_pkg::out_flags_t  out_flags_q, out_flags_d;

  assign in_word.cmd       = hne_pkg::cmd_e'(s_axis_tuser_i[0]);
  assign in_word.base_word = s_axis_tdata_i;

  hne_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .word_i  (in_word),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .word_o  (s1_word)
  );

  hne_mask_step #(
    .WordBits (WORD_BITS)
  ) u_mask_step (
    .mask_i      (mask_q),
    .next_mask_o (next_mask),
    .has_next_o  (has_next)
  );

  assign s1_ready  = !out_valid_q || m_axis_tready_i;
  assign adv       = s1_valid && s1_ready;
  assign dist_over = 32'(dist_q) > 32'(WORD_BITS);

  // top dist_q bits set
  always_comb begin
    for (int j = 0; j < int'(WORD_BITS); j++) begin
      start_mask[j] = (32'(j) + 32'(dist_q)) >= 32'(WORD_BITS);
    end
  end

  always_comb begin
    held_base_d                = held_base_q;
    mask_d                     = mask_q;
    pend_d                     = pend_q;
    out_word_d                 = '0;
    out_flags_d.neighbor_valid = 1'b0;
    case (s1_word.cmd)
      hne_pkg::CMD_START: begin
        held_base_d = s1_word.base_word[BaseBits-1:0];
        if (dist_over) begin
          mask_d = '0;
          pend_d = 1'b0;
        end else begin
          mask_d = start_mask;
          pend_d = 1'b1;
        end
      end
      hne_pkg::CMD_NEXT: begin
        if (pend_q) begin
          out_word_d                 = DataW'(held_base_q ^ mask_q[BaseBits-1:0]);
          out_flags_d.neighbor_valid = 1'b1;
          if (has_next) begin
            mask_d = next_mask;
          end else begin
            mask_d = '0;
            pend_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    out_flags_d.more_left = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q      <= DistW'(1);
      held_base_q <= '0;
      mask_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dist_q <= cfg_wdata_i;
      end
      if (adv) begin
        held_base_q <= held_base_d;
        mask_q      <= mask_d;
        pend_q      <= pend_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q  <= out_word_d;
      out_flags_q <= out_flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_flags_q;

  `HNE_ASSERT(a_idle_mask_zero, clk_i, rst_ni, !pend_q |-> (mask_q == '0))
  `HNE_ASSERT(a_next_yields, clk_i, rst_ni, (adv && (s1_word.cmd == hne_pkg::CMD_NEXT) && pend_q) |=> (out_valid_q && out_flags_q.neighbor_valid))
  `HNE_ASSERT(a_empty_accepts, clk_i, rst_ni, !out_valid_q |-> s_axis_tready_o)
  `HNE_ASSERT_NEVER(a_word_without_valid, clk_i, rst_ni, out_valid_q && !out_flags_q.neighbor_valid && (out_word_q != '0))

endmodule

// ===== hw/rtl/hne_in_reg.sv =====
// Input register stage of the enumerator.
module hne_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hne_pkg::in_word_t word_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hne_pkg::in_word_t word_o
);

  logic             valid_q;
  hne_pkg::in_word_t word_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

endmodule

// ===== hw/rtl/hne_mask_step.sv =====
// Next smaller flip mask of the same weight.
module hne_mask_step #(
  parameter int unsigned WordBits = 16
) (
  input  logic [WordBits-1:0] mask_i,
  output logic [WordBits-1:0] next_mask_o,
  output logic                has_next_o
);

  localparam int unsigned IdxBits = (WordBits > 1) ? $clog2(WordBits) : 1;
  localparam int unsigned ShBits  = $clog2(WordBits + 1);
  localparam logic [WordBits-1:0] One = WordBits'(1);

  logic [WordBits-1:0] inc;
  logic [WordBits-1:0] low_zero;
  logic [WordBits-1:0] trimmed;
  logic [WordBits-1:0] top_bit;
  logic [WordBits-1:0] sub_val;
  logic [IdxBits-1:0]  ones_run;
  logic [ShBits-1:0]   sh_amt;

  // m = H 1 0^a 1^k  ->  H 0 1^(k+1) 0^(a-1)  =  (m & (m+1)) - 2^(p-k-1)
  assign inc      = mask_i + One;
  assign trimmed  = mask_i & inc;
  assign low_zero = ~mask_i & inc;
  assign top_bit  = trimmed & (~trimmed + One);

  always_comb begin
    ones_run = '0;
    for (int i = 0; i < int'(WordBits); i++) begin
      if (low_zero[i]) begin
        ones_run = ones_run | IdxBits'(i);
      end
    end
  end

  assign sh_amt      = ShBits'(ones_run) + ShBits'(1);
  assign sub_val     = top_bit >> sh_amt;
  assign next_mask_o = trimmed - sub_val;
  assign has_next_o  = |trimmed;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the Hamming neighbor enumerator: directed and random stream traffic.
module tb_top;

  typedef struct {
    logic [15:0]         word;
    hne_pkg::out_flags_t flags;
  } neighbor_t;

  class neighbor_predictor;
    logic [4:0]  distance;
    logic [15:0] base;
    logic [15:0] mask;
    bit          armed;
    neighbor_t   expected_neighbors[$];
    int          mismatches;

    function new();
      distance   = 5'd1;
      base       = '0;
      mask       = '0;
      armed      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_distance(logic [4:0] d);
      distance = d;
    endfunction

    // next smaller mask of the same weight; 0 when the weight is used up
    function bit step_mask(input logic [15:0] m, output logic [15:0] nxt);
      int          k;
      logic [31:0] r;
      for (int p = 1; p < 16; p++) begin
        if (m[p] && !m[p-1]) begin
          k = $countones(m & ((32'h1 << p) - 1));
          r = m & ~((32'h1 << (p + 1)) - 1);
          r |= 32'h1 << (p - 1);
          r |= ((32'h1 << k) - 1) << (p - 1 - k);
          nxt = r[15:0];
          return 1'b1;
        end
      end
      nxt = '0;
      return 1'b0;
    endfunction

    function void take_command(hne_pkg::cmd_e c, logic [15:0] w);
      neighbor_t   res;
      logic [15:0] nxt;
      res.word                 = '0;
      res.flags.neighbor_valid = 1'b0;
      if (c == hne_pkg::CMD_START) begin
        base = w;
        if (distance > 5'd16) begin
          mask  = '0;
          armed = 1'b0;
        end else begin
          mask  = 16'((32'h1 << distance) - 1) << (16 - distance);
          armed = 1'b1;
        end
      end else if (armed) begin
        res.word                 = base ^ mask;
        res.flags.neighbor_valid = 1'b1;
        if (step_mask(mask, nxt)) begin
          mask = nxt;
        end else begin
          mask  = '0;
          armed = 1'b0;
        end
      end
      res.flags.more_left = armed;
      expected_neighbors.insert(expected_neighbors.size(), res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH %0t: %s", $time, msg);
    endtask

    task match_result(logic [15:0] w, hne_pkg::out_flags_t f);
      neighbor_t exp_n;
      if (expected_neighbors.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h flags %b", w, f));
        return;
      end
      exp_n = expected_neighbors.pop_front();
      if (w !== exp_n.word)
        report_mismatch($sformatf("neighbor_word %h, expected %h", w, exp_n.word));
      if (f.neighbor_valid !== exp_n.flags.neighbor_valid)
        report_mismatch($sformatf("neighbor_valid %b, expected %b",
                                  f.neighbor_valid, exp_n.flags.neighbor_valid));
      if (f.more_left !== exp_n.flags.more_left)
        report_mismatch($sformatf("more_left %b, expected %b",
                                  f.more_left, exp_n.flags.more_left));
    endtask

    function int outstanding();
      return expected_neighbors.size();
    endfunction
  endclass

  localparam int StallLimit = 2000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [4:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;   // [15:0] base_word
  logic [0:0]  s_axis_tuser_i  = '0;   // [0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;         // [15:0] neighbor_word
  logic [1:0]  m_axis_tuser_o;         // [0] neighbor_valid, [1] more_left

  neighbor_predictor nbr = new();
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_cycles  = 0;

  hamming_neighbor_enumerator #(
    .WORD_BITS(16)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // handshakes are settled by the falling edge and hold until the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        nbr.match_result(m_axis_tdata_o, hne_pkg::out_flags_t'(m_axis_tuser_o));
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("hamming_neighbor_enumerator regression: fail");
      $finish;
    end
  end

  task automatic send_word(hne_pkg::cmd_e c, logic [15:0] d);
    bit hit;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= c;
    s_axis_tdata_i  <= d;
    do begin
      @(negedge clk_i);
      hit = s_axis_tready_o;
      @(posedge clk_i);
    end while (!hit);
    nbr.take_command(c, d);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (nbr.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_distance(logic [4:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    nbr.set_distance(v);
  endtask

  task automatic random_traffic(int n_words);
    int          sent;
    int          r;
    int          n;
    int          total;
    logic [15:0] b;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 85) begin
        r = $urandom_range(9);
        b = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : 16'($urandom);
        send_word(hne_pkg::CMD_START, b);
        total = 0;
        if (nbr.distance <= 5'd16) begin
          total = 1;
          for (int i = 0; i < nbr.distance; i++) total = total * (16 - i) / (i + 1);
        end
        if (total != 0 && total <= 130 && $urandom_range(2) == 0)
          n = total + $urandom_range(0, 2);
        else
          n = $urandom_range(1, 12);
        repeat (n) send_word(hne_pkg::CMD_NEXT, 16'($urandom));
        sent += n + 1;
      end else begin
        send_word((r < 93) ? hne_pkg::CMD_NEXT : hne_pkg::CMD_START, 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [4:0] phase_dist[8];
    phase_dist = '{5'd2, 5'd0, 5'd16, 5'd1, 5'd14, 5'd31, 5'd15, 5'd3};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // distance 1 from reset; next before any start
    send_word(hne_pkg::CMD_NEXT, 16'hffff);
    send_word(hne_pkg::CMD_START, 16'ha5a5);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    write_distance(5'd0);
    send_word(hne_pkg::CMD_START, 16'hffff);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    write_distance(5'd16);
    send_word(hne_pkg::CMD_START, 16'h0000);
    send_word(hne_pkg::CMD_NEXT, 16'hffff);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    write_distance(5'd17);
    send_word(hne_pkg::CMD_START, 16'h1234);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    write_distance(5'd31);
    send_word(hne_pkg::CMD_START, 16'hffff);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    write_distance(5'd2);
    send_word(hne_pkg::CMD_START, 16'h8001);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    // new distance must not disturb the walk in progress
    write_distance(5'd15);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    send_word(hne_pkg::CMD_START, 16'h0000);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    send_word(hne_pkg::CMD_START, 16'hffff);
    send_word(hne_pkg::CMD_START, 16'h5a5a);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);
    send_word(hne_pkg::CMD_NEXT, 16'h0000);

    for (int p = 0; p < 8; p++) begin
      write_distance(phase_dist[p]);
      src_idle_pct    = (p % 4 == 1) ? 56 : (p % 4 == 3) ? 32 : 0;
      sink_stall_pct <= (p % 4 == 2) ? 56 : (p % 4 == 3) ? 32 : 0;
      random_traffic(90);
      wait_drained();
      if ($urandom_range(1) == 1) write_distance(5'($urandom_range(0, 31)));
      random_traffic(90);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (nbr.mismatches == 0) begin
      $display("hamming_neighbor_enumerator regression: pass");
    end else begin
      $display("hamming_neighbor_enumerator regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hne_pkg.sv
hw/rtl/hne_in_reg.sv
hw/rtl/hne_mask_step.sv
hw/rtl/hamming_neighbor_enumerator.sv
sim/tb_top.sv
